/* design/cfrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrr_pkg
// Shared types, codes and the CRC-8 step function of the frame receiver ring.
// ----------------------------------------------------------------------------
package cfrr_pkg;

    localparam int CPayloadBytes = 8;
    localparam int CRingFrames   = 8;

    localparam int ByteW    = 8;
    localparam int CmdW     = 2;
    localparam int KindW    = 3;
    localparam int TimeoutW = 16;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    localparam logic [ByteW-1:0]    StartByteRst = 8'd126;
    localparam logic [TimeoutW-1:0] TimeoutRst   = 16'd1000;
    localparam logic [ByteW-1:0]    CrcPoly      = 8'h70;

    localparam logic [CmdW-1:0] CMD_BYTE = 2'd0;
    localparam logic [CmdW-1:0] CMD_READ = 2'd1;
    localparam logic [CmdW-1:0] CMD_TICK = 2'd2;

    localparam logic [KindW-1:0] KIND_ACK     = 3'd0;
    localparam logic [KindW-1:0] KIND_NACK    = 3'd1;
    localparam logic [KindW-1:0] KIND_DROP    = 3'd2;
    localparam logic [KindW-1:0] KIND_READ    = 3'd3;
    localparam logic [KindW-1:0] KIND_NOFRAME = 3'd4;
    localparam logic [KindW-1:0] KIND_TIMEOUT = 3'd5;

    localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 1'd1;

    typedef struct packed {
        logic accept;
        logic out_load_item;
        logic out_load_hold;
        logic out_load_read;
        logic hold_load;
        logic rd_next;
    } t_ctl_cmd;

    typedef struct packed {
        logic res_valid;
        logic read_go;
        logic out_free;
        logic rd_last;
    } t_dp_status;

    function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                     input logic [ByteW-1:0] b);
        logic [ByteW-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < ByteW; i++) begin
            if (c[ByteW-1]) begin
                c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[ByteW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/cfrr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrr_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cfrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/cfrr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrr_ctrl
// Controller: accepts items, sequences frame reads and moves results out.
// ----------------------------------------------------------------------------
module cfrr_ctrl import cfrr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HOLD = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    if (i_status.read_go) begin
                        n_state = S_READ;
                    end else if (i_status.res_valid) begin
                        if (i_status.out_free) begin
                            o_ctl.out_load_item = 1'b1;
                        end else begin
                            o_ctl.hold_load = 1'b1;
                            n_state         = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_ctl.out_load_hold = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    o_ctl.out_load_read = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/cfrr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrr_dp
// Datapath: framing state, CRC, frame ring memory, holding stage and output.
// ----------------------------------------------------------------------------
module cfrr_dp import cfrr_pkg::*; #(
    parameter int PAYLOAD_BYTES = CPayloadBytes,
    parameter int RING_FRAMES   = CRingFrames
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl_cmd            i_ctl,
    output t_dp_status          o_status,
    input  logic [CmdW-1:0]     i_cmd,
    input  logic [ByteW-1:0]    i_rx_byte,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [KindW-1:0]    o_kind,
    output logic [ByteW-1:0]    o_data_byte,
    output logic                o_last,
    output logic                o_frames_waiting
);

    localparam int Depth = PAYLOAD_BYTES * RING_FRAMES;
    localparam int AddrW = $clog2(Depth);
    localparam int SlotW = $clog2(RING_FRAMES);
    localparam int CntW  = $clog2(PAYLOAD_BYTES + 1);
    localparam int IdxW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic [ByteW-1:0]    r_start_byte;
    logic [TimeoutW-1:0] r_timeout;
    logic                r_in_frame;
    logic [CntW-1:0]     r_count;
    logic [ByteW-1:0]    r_crc;
    logic [SlotW-1:0]    r_wr_slot;
    logic [SlotW-1:0]    r_rd_slot;
    logic                r_has_frames;
    logic [TimeoutW-1:0] r_idle;
    logic                r_lost;
    logic [AddrW-1:0]    r_rd_base;
    logic [IdxW-1:0]     r_rd_idx;
    logic [KindW-1:0]    r_hold_kind;
    logic                r_out_valid;
    logic [KindW-1:0]    r_out_kind;
    logic [ByteW-1:0]    r_out_data;
    logic                r_out_last;
    logic                r_out_fw;

    logic                n_in_frame;
    logic [CntW-1:0]     n_count;
    logic [ByteW-1:0]    n_crc;
    logic [SlotW-1:0]    n_wr_slot;
    logic [SlotW-1:0]    n_rd_slot;
    logic                n_has_frames;
    logic [TimeoutW-1:0] n_idle;
    logic                n_lost;

    logic                full;
    logic [SlotW-1:0]    wr_slot_inc;
    logic [SlotW-1:0]    rd_slot_inc;
    logic [TimeoutW-1:0] tick_cnt;
    logic [AddrW-1:0]    wr_base;
    logic [AddrW-1:0]    rd_cur_base;
    logic                res_valid;
    logic [KindW-1:0]    res_kind;
    logic                read_go;
    logic                store_byte;
    logic                ram_wr_en;
    logic [AddrW-1:0]    ram_wr_addr;
    logic                ram_rd_en;
    logic [AddrW-1:0]    ram_rd_addr;
    logic [ByteW-1:0]    ram_rd_data;
    logic                rd_last;
    logic                out_free;
    logic                read_start;

    assign full        = r_has_frames && (r_wr_slot == r_rd_slot);
    assign wr_slot_inc = (r_wr_slot == SlotW'(RING_FRAMES - 1)) ? '0 : r_wr_slot + SlotW'(1);
    assign rd_slot_inc = (r_rd_slot == SlotW'(RING_FRAMES - 1)) ? '0 : r_rd_slot + SlotW'(1);
    assign tick_cnt    = r_idle + TimeoutW'(1);
    assign wr_base     = AddrW'(r_wr_slot) * AddrW'(PAYLOAD_BYTES);
    assign rd_cur_base = AddrW'(r_rd_slot) * AddrW'(PAYLOAD_BYTES);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_count      = r_count;
        n_crc        = r_crc;
        n_wr_slot    = r_wr_slot;
        n_rd_slot    = r_rd_slot;
        n_has_frames = r_has_frames;
        n_idle       = r_idle;
        n_lost       = r_lost;
        res_valid    = 1'b0;
        res_kind     = KIND_ACK;
        read_go      = 1'b0;
        store_byte   = 1'b0;
        unique case (i_cmd)
            CMD_BYTE: begin
                if (!r_in_frame) begin
                    if (i_rx_byte == r_start_byte) begin
                        n_in_frame = 1'b1;
                        n_count    = '0;
                        n_crc      = r_start_byte;
                        n_idle     = '0;
                        n_lost     = 1'b0;
                    end
                end else if (r_count < CntW'(PAYLOAD_BYTES)) begin
                    if (full) begin
                        n_lost = 1'b1;
                    end else begin
                        store_byte = 1'b1;
                    end
                    n_count = r_count + CntW'(1);
                    n_crc   = crc8_update(r_crc, i_rx_byte);
                end else begin
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    n_idle     = '0;
                    res_valid  = 1'b1;
                    if (i_rx_byte != r_crc) begin
                        res_kind = KIND_NACK;
                    end else if (full || r_lost) begin
                        res_kind = KIND_DROP;
                    end else begin
                        res_kind     = KIND_ACK;
                        n_wr_slot    = wr_slot_inc;
                        n_has_frames = 1'b1;
                    end
                    n_lost = 1'b0;
                end
            end
            CMD_READ: begin
                if (!r_has_frames) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_NOFRAME;
                end else begin
                    read_go   = 1'b1;
                    n_rd_slot = rd_slot_inc;
                    if (rd_slot_inc == r_wr_slot) begin
                        n_has_frames = 1'b0;
                    end
                end
            end
            CMD_TICK: begin
                if (r_in_frame) begin
                    n_idle = tick_cnt;
                    if (tick_cnt >= r_timeout || tick_cnt == '0) begin
                        n_in_frame = 1'b0;
                        n_count    = '0;
                        n_idle     = '0;
                        n_lost     = 1'b0;
                        res_valid  = 1'b1;
                        res_kind   = KIND_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign read_start  = i_ctl.accept && read_go;
    assign ram_wr_en   = i_ctl.accept && store_byte;
    assign ram_wr_addr = wr_base + AddrW'(r_count);
    assign ram_rd_en   = read_start || i_ctl.rd_next;
    assign ram_rd_addr = read_start ? rd_cur_base
                                    : r_rd_base + AddrW'(r_rd_idx) + AddrW'(1);
    assign rd_last     = (r_rd_idx == IdxW'(PAYLOAD_BYTES - 1));
    assign out_free    = !r_out_valid || !i_out_stall;

    cfrr_ram #(
        .WIDTH (ByteW),
        .DEPTH (Depth)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= StartByteRst;
            r_timeout    <= TimeoutRst;
            r_in_frame   <= 1'b0;
            r_count      <= '0;
            r_crc        <= StartByteRst;
            r_wr_slot    <= '0;
            r_rd_slot    <= '0;
            r_has_frames <= 1'b0;
            r_idle       <= '0;
            r_lost       <= 1'b0;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_BYTE: r_start_byte <= i_cfg_data[ByteW-1:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data[TimeoutW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_ctl.accept) begin
                r_in_frame   <= n_in_frame;
                r_count      <= n_count;
                r_crc        <= n_crc;
                r_wr_slot    <= n_wr_slot;
                r_rd_slot    <= n_rd_slot;
                r_has_frames <= n_has_frames;
                r_idle       <= n_idle;
                r_lost       <= n_lost;
            end
            if (read_start) begin
                r_rd_idx <= '0;
            end else if (i_ctl.rd_next) begin
                r_rd_idx <= r_rd_idx + IdxW'(1);
            end
            if (i_ctl.out_load_item || i_ctl.out_load_hold || i_ctl.out_load_read) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (read_start) begin
            r_rd_base <= rd_cur_base;
        end
        if (i_ctl.hold_load) begin
            r_hold_kind <= res_kind;
        end
        if (i_ctl.out_load_item) begin
            r_out_kind <= res_kind;
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_fw   <= n_has_frames;
        end else if (i_ctl.out_load_hold) begin
            r_out_kind <= r_hold_kind;
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_fw   <= r_has_frames;
        end else if (i_ctl.out_load_read) begin
            r_out_kind <= KIND_READ;
            r_out_data <= ram_rd_data;
            r_out_last <= rd_last;
            r_out_fw   <= r_has_frames;
        end
    end

    assign o_status.res_valid = res_valid;
    assign o_status.read_go   = read_go;
    assign o_status.out_free  = out_free;
    assign o_status.rd_last   = rd_last;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_data_byte      = r_out_data;
    assign o_last           = r_out_last;
    assign o_frames_waiting = r_out_fw;

endmodule

/* design/crc8_frame_receiver_ring_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_ring_unit
// Start-byte framed receiver with CRC-8 check and a ring of stored frames.
// ----------------------------------------------------------------------------
// A received byte or a millisecond tick gives at most one result beat. A read
// of a stored frame occupies the block until its last byte is loaded out; its
// bytes come one per cycle, while the output is not stalled, from the single
// read port of the frame memory. An item is taken while the previous result
// still waits in the output register. The frame memory is not cleared after
// reset, so the block is ready at once.
module crc8_frame_receiver_ring_unit import cfrr_pkg::*; #(
    parameter int PAYLOAD_BYTES = CPayloadBytes,
    parameter int RING_FRAMES   = CRingFrames
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CmdW-1:0]     i_cmd,
    input  logic [ByteW-1:0]    i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KindW-1:0]    o_kind,
    output logic [ByteW-1:0]    o_data_byte,
    output logic                o_last,
    output logic                o_frames_waiting,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_ctl_cmd   ctl;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    cfrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    cfrr_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .RING_FRAMES   (RING_FRAMES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_status         (status),
        .i_cmd            (i_cmd),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_last           (o_last),
        .o_frames_waiting (o_frames_waiting)
    );

endmodule

/* design/cfrr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrr_checker
// Port-level checks of the frame receiver ring, bound to the top level.
// ----------------------------------------------------------------------------
module cfrr_checker import cfrr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [CmdW-1:0]     i_cmd,
    input logic [ByteW-1:0]    i_rx_byte,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [KindW-1:0]    o_kind,
    input logic [ByteW-1:0]    o_data_byte,
    input logic                o_last,
    input logic                o_frames_waiting,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [CfgIdxW-1:0]  i_cfg_index,
    input logic [CfgDataW-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output beat dropped while stalled.");

    a_status_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_READ |-> o_data_byte == '0 && o_last)
        else $error("Status beat carries data or is not last.");

    a_noframe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_NOFRAME |-> !o_frames_waiting)
        else $error("Empty-ring report with frames waiting.");

    a_ack_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACK |-> o_frames_waiting)
        else $error("Stored frame not shown as waiting.");

endmodule

bind crc8_frame_receiver_ring_unit cfrr_checker u_checker (.*);

/* sim/crc8_frame_receiver_ring_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_ring_unit_test
// Self-checking testbench for the CRC-8 frame receiver ring. Directed tests
// cover the empty ring, a good frame, a CRC mismatch and the tick timeout.
// Random traffic then runs under several register settings with random gaps
// and stalls on both channels. A behavioral predictor tracks framing, CRC,
// ring and timeout state and checks every result beat field by field.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_ring_unit_test import cfrr_pkg::*; ;

    localparam int ResetCycles  = 11;
    localparam int MaxWait      = 19;
    localparam int SettleCycles = 16;
    localparam int StallLimit   = 3000;
    localparam int StoreBytes   = CPayloadBytes * CRingFrames;

    localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] data;
        logic             last;
        logic             waiting;
    } t_beat;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CmdW-1:0]     in_cmd    = CMD_BYTE;
    logic [ByteW-1:0]    in_byte   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KindW-1:0]    out_kind;
    logic [ByteW-1:0]    out_data;
    logic                out_last;
    logic                out_waiting;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = CFG_START_BYTE;
    logic [CfgDataW-1:0] cfg_data  = '0;

    // Predictor state.
    logic [ByteW-1:0]    cfg_start_byte  = StartByteRst;
    logic [TimeoutW-1:0] cfg_timeout     = TimeoutRst;
    logic                rx_in_frame     = 1'b0;
    int                  rx_count        = 0;
    logic [ByteW-1:0]    rx_crc          = StartByteRst;
    logic                rx_lost         = 1'b0;
    logic [TimeoutW-1:0] frame_ticks     = '0;
    logic [ByteW-1:0]    ring_mem [StoreBytes];
    int                  wr_slot         = 0;
    int                  rd_slot         = 0;
    logic                ring_has_frames = 1'b0;

    t_beat pending_beats [$];
    t_beat want;
    int    error_count = 0;
    int    items_sent  = 0;
    int    stall_left  = 0;
    int    idle_cycles = 0;
    bit    quiet       = 1'b0;

    crc8_frame_receiver_ring_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (in_cmd),
        .i_rx_byte        (in_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (out_kind),
        .o_data_byte      (out_data),
        .o_last           (out_last),
        .o_frames_waiting (out_waiting),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [ByteW-1:0] crc8_next(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
        logic [ByteW-1:0] r;
        r = crc ^ b;
        repeat (ByteW) r = r[ByteW-1] ? ((r << 1) ^ CrcPoly) : (r << 1);
        return r;
    endfunction

    function automatic bit ring_full();
        return ring_has_frames && wr_slot == rd_slot;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic predict_rx_item(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b);
        t_beat beats [$];
        t_beat one;
        one = '0;
        one.last = 1'b1;
        case (c)
            CMD_BYTE: begin
                if (!rx_in_frame) begin
                    if (b == cfg_start_byte) begin
                        rx_in_frame = 1'b1;
                        rx_count    = 0;
                        rx_crc      = cfg_start_byte;
                        frame_ticks = '0;
                        rx_lost     = 1'b0;
                    end
                end else if (rx_count < CPayloadBytes) begin
                    if (ring_full()) begin
                        rx_lost = 1'b1;
                    end else begin
                        ring_mem[wr_slot * CPayloadBytes + rx_count] = b;
                    end
                    rx_count++;
                    rx_crc = crc8_next(rx_crc, b);
                end else begin
                    rx_in_frame = 1'b0;
                    rx_count    = 0;
                    frame_ticks = '0;
                    if (b != rx_crc) begin
                        one.kind = KIND_NACK;
                    end else if (ring_full() || rx_lost) begin
                        one.kind = KIND_DROP;
                    end else begin
                        wr_slot         = (wr_slot + 1) % CRingFrames;
                        ring_has_frames = 1'b1;
                        one.kind        = KIND_ACK;
                    end
                    rx_lost = 1'b0;
                    beats.push_back(one);
                end
            end
            CMD_READ: begin
                if (!ring_has_frames) begin
                    one.kind = KIND_NOFRAME;
                    beats.push_back(one);
                end else begin
                    for (int i = 0; i < CPayloadBytes; i++) begin
                        one.kind = KIND_READ;
                        one.data = ring_mem[rd_slot * CPayloadBytes + i];
                        one.last = (i == CPayloadBytes - 1);
                        beats.push_back(one);
                    end
                    rd_slot = (rd_slot + 1) % CRingFrames;
                    if (rd_slot == wr_slot) ring_has_frames = 1'b0;
                end
            end
            CMD_TICK: begin
                if (rx_in_frame) begin
                    frame_ticks = frame_ticks + 1'b1;
                    if (frame_ticks >= cfg_timeout || frame_ticks == '0) begin
                        rx_in_frame = 1'b0;
                        rx_count    = 0;
                        frame_ticks = '0;
                        rx_lost     = 1'b0;
                        one.kind    = KIND_TIMEOUT;
                        beats.push_back(one);
                    end
                end
            end
            default: ;
        endcase
        foreach (beats[i]) begin
            pending_beats.push_back({beats[i].kind, beats[i].data, beats[i].last,
                                     ring_has_frames});
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MaxWait);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_cmd   = c;
        in_byte  = b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_rx_item(c, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == CFG_START_BYTE) begin
            cfg_start_byte = val[ByteW-1:0];
        end else begin
            cfg_timeout = val;
        end
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // A cut_at of 1 to CPayloadBytes stops the frame after that many payload beats.
    task automatic send_frame(input logic [ByteW-1:0] body [CPayloadBytes],
                              input logic [ByteW-1:0] crc_flip, input int cut_at,
                              input int tick_pct, input int read_pct);
        logic [ByteW-1:0] crc;
        crc = cfg_start_byte;
        send_item(CMD_BYTE, cfg_start_byte);
        for (int i = 0; i <= CPayloadBytes; i++) begin
            if (i == cut_at) return;
            if ($urandom_range(0, 99) < tick_pct) send_item(CMD_TICK, 8'($urandom));
            if ($urandom_range(0, 99) < read_pct) send_item(CMD_READ, 8'($urandom));
            if (i < CPayloadBytes) begin
                crc = crc8_next(crc, body[i]);
                send_item(CMD_BYTE, body[i]);
            end else begin
                send_item(CMD_BYTE, crc ^ crc_flip);
            end
        end
    endtask

    task automatic run_traffic(input int goal, input int read_pct, input int tick_pct);
        logic [ByteW-1:0] body [CPayloadBytes];
        int pick;
        int stop_at;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0) quiet = ~quiet;
            pick = $urandom_range(0, 99);
            if (pick < read_pct) begin
                send_item(CMD_READ, 8'($urandom));
            end else if (pick < read_pct + 6) begin
                send_item(CMD_TICK, 8'($urandom));
            end else if (pick < read_pct + 10) begin
                send_item(CMD_BYTE, 8'($urandom));
            end else if (pick < read_pct + 12) begin
                send_item(CMD_UNUSED, 8'($urandom));
            end else begin
                foreach (body[i]) body[i] = 8'($urandom);
                send_frame(body,
                           ($urandom_range(0, 7) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, CPayloadBytes) : -1,
                           tick_pct, read_pct / 3);
            end
        end
    endtask

    task automatic test_empty_ring();
        send_item(CMD_READ, 8'h00);
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
    endtask

    task automatic test_good_frame();
        logic [ByteW-1:0] body [CPayloadBytes];
        foreach (body[i]) body[i] = (i % 2) ? 8'hFF : 8'h00;
        body[2] = cfg_start_byte;
        send_frame(body, 8'h00, -1, 0, 0);
        send_item(CMD_READ, 8'h5A);
    endtask

    task automatic test_crc_mismatch();
        logic [ByteW-1:0] body [CPayloadBytes];
        foreach (body[i]) body[i] = 8'($urandom);
        send_frame(body, 8'h80, -1, 0, 0);
    endtask

    task automatic test_timeout();
        settle();
        write_reg(CFG_START_BYTE, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_TICK, 8'h00);
        settle();
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
    endtask

    task automatic test_ring_overflow();
        settle();
        write_reg(CFG_START_BYTE, {8'($urandom), 8'hFF});
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        run_traffic(130, 3, 5);
    endtask

    task automatic test_timeout_traffic();
        settle();
        write_reg(CFG_START_BYTE, 16'($urandom));
        write_reg(CFG_TIMEOUT, 16'd3);
        run_traffic(120, 20, 15);
    endtask

    task automatic test_mixed_traffic();
        settle();
        write_reg(CFG_START_BYTE, {8'h00, StartByteRst});
        write_reg(CFG_TIMEOUT, TimeoutRst);
        run_traffic(130, 15, 5);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_beats.size() == 0) begin
                report($sformatf("unexpected beat kind %0d data %02h", out_kind, out_data));
            end else begin
                want = pending_beats.pop_front();
                if (out_kind !== want.kind)
                    report($sformatf("kind %0d, expected %0d", out_kind, want.kind));
                if (out_data !== want.data)
                    report($sformatf("data_byte %02h, expected %02h", out_data, want.data));
                if (out_last !== want.last)
                    report($sformatf("last %b, expected %b", out_last, want.last));
                if (out_waiting !== want.waiting)
                    report($sformatf("frames_waiting %b, expected %b",
                                     out_waiting, want.waiting));
            end
            stall_left = quiet ? 0 : $urandom_range(0, MaxWait);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_ring();
        test_good_frame();
        test_crc_mismatch();
        test_timeout();
        test_ring_overflow();
        test_timeout_traffic();
        test_mixed_traffic();
        in_valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
